/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labelled concurrent assertion on the given clock,
// switched off while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lew_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor package
// Shared types, action codes and register defaults of the word-wrap editor.
// ----------------------------------------------------------------------------
package lew_pkg;

   localparam int LINE_LENGTH_DEF = 32;

   localparam int SYM_W = 8;
   localparam int ACT_W = 3;
   localparam int CNT_W = 6;
   localparam int CSR_IDX_W = 2;

   // Result action codes.
   localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ERASE   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_BELL    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_END     = 3'd4;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KILL       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_ERASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END        = 2'd3;

   // Register values after reset.
   localparam logic [SYM_W-1:0] ERASE_CHAR_RST      = 8'd127;
   localparam logic [SYM_W-1:0] KILL_CHAR_RST       = 8'd21;
   localparam logic [SYM_W-1:0] WORD_ERASE_CHAR_RST = 8'd23;
   localparam logic [SYM_W-1:0] END_CHAR_RST        = 8'd4;

   // Printable range; the space is the only blank that can be stored.
   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [SYM_W-1:0] CHAR_TILDE = 8'h7E;

   typedef struct packed {
      logic [SYM_W-1:0] erase_char;
      logic [SYM_W-1:0] kill_char;
      logic [SYM_W-1:0] word_erase_char;
      logic [SYM_W-1:0] end_char;
   } cfg_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [SYM_W-1:0] out_char;
      logic [CNT_W-1:0] erase_count;
      logic             last;
   } result_type;

endpackage

/* rtl/lew_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read character memory with a registered read.
// ----------------------------------------------------------------------------
module lew_store #(
   parameter int DEPTH = lew_pkg::LINE_LENGTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [lew_pkg::SYM_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [lew_pkg::SYM_W-1:0] rd_data
);

   logic [lew_pkg::SYM_W-1:0] line_ff [DEPTH];
   logic [lew_pkg::SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lew_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result for the receiver so that the sequencer can move on.
// ----------------------------------------------------------------------------
module lew_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lew_pkg::result_type        push_data,
   output logic                       push_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lew_pkg::ACT_W-1:0]  rsp_action,
   output logic [lew_pkg::SYM_W-1:0]  rsp_out_char,
   output logic [lew_pkg::CNT_W-1:0]  rsp_erase_count,
   output logic                       rsp_last
);

   logic                valid_ff;
   logic                valid_in;
   lew_pkg::result_type data_ff;

   // The register may be refilled in the same cycle as its transfer goes out.
   assign push_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (push && push_ready) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_action      = data_ff.action;
   assign rsp_out_char    = data_ff.out_char;
   assign rsp_erase_count = data_ff.erase_count;
   assign rsp_last        = data_ff.last;

endmodule

/* rtl/lew_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor sequencer
// Decodes each byte and walks the line store one character per step.
// ----------------------------------------------------------------------------
module lew_ctrl #(
   parameter int LINE_LENGTH = lew_pkg::LINE_LENGTH_DEF,
   parameter int AW          = $clog2(LINE_LENGTH),
   parameter int LW          = $clog2(LINE_LENGTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lew_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lew_pkg::SYM_W-1:0]  req_symbol,
   output logic                       push,
   output lew_pkg::result_type        push_data,
   input  logic                       push_ready,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [lew_pkg::SYM_W-1:0]  wr_data,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  logic [lew_pkg::SYM_W-1:0]  rd_data
);

   localparam logic [LW-1:0] LEN_MAX  = LW'(LINE_LENGTH);
   localparam logic [AW-1:0] SRC_LAST = AW'(LINE_LENGTH - 1);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_DECODE = 11'b000_0000_0010,
      S_WE_REQ = 11'b000_0000_0100,
      S_WE_CHK = 11'b000_0000_1000,
      S_WR_REQ = 11'b000_0001_0000,
      S_WR_CHK = 11'b000_0010_0000,
      S_WR_NL  = 11'b000_0100_0000,
      S_MV_REQ = 11'b000_1000_0000,
      S_MV_CHK = 11'b001_0000_0000,
      S_CHAR   = 11'b010_0000_0000,
      S_OUT    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic [lew_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic word_ff, word_in;
   logic single_ff, single_in;
   lew_pkg::result_type res_ff, res_in;

   logic [LW-1:0] ptr_dec;
   logic [LW-1:0] we_end;
   logic [LW-1:0] wrap_start;
   logic [LW-1:0] keep;
   logic          is_space;
   logic          printable;
   logic          mv_final;

   // Shared step unit: one decrement and one compare against the space code.
   assign ptr_dec    = ptr_ff - LW'(1);
   assign is_space   = (rd_data == lew_pkg::CHAR_SPACE);
   assign printable  = sym_ff inside {[lew_pkg::CHAR_SPACE:lew_pkg::CHAR_TILDE]};
   assign we_end     = (word_ff && is_space) ? ptr_ff : ptr_dec;
   assign wrap_start = is_space ? ptr_ff : '0;
   assign keep       = LEN_MAX - wrap_start;
   assign mv_final   = (src_ff == SRC_LAST);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      sym_in    = sym_ff;
      len_in    = len_ff;
      ptr_in    = ptr_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      word_in   = word_ff;
      single_in = single_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = dst_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = ptr_dec[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sym_in   = req_symbol;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_IDLE;
            ret_in   = S_IDLE;
            if (sym_ff == cfg.erase_char) begin
               if (len_ff != '0) begin
                  len_in   = len_ff - LW'(1);
                  res_in   = '{lew_pkg::ACT_ERASE, '0, lew_pkg::CNT_W'(1), 1'b1};
                  state_in = S_OUT;
               end
            end else if (sym_ff == cfg.kill_char) begin
               if (len_ff != '0) begin
                  len_in   = '0;
                  res_in   = '{lew_pkg::ACT_ERASE, '0, lew_pkg::CNT_W'(len_ff), 1'b1};
                  state_in = S_OUT;
               end
            end else if (sym_ff == cfg.word_erase_char) begin
               if (len_ff != '0) begin
                  ptr_in   = len_ff;
                  word_in  = 1'b0;
                  state_in = S_WE_REQ;
               end
            end else if (sym_ff == cfg.end_char && len_ff == '0) begin
               res_in   = '{lew_pkg::ACT_END, '0, '0, 1'b1};
               state_in = S_OUT;
            end else if (len_ff == LEN_MAX) begin
               ptr_in   = LEN_MAX;
               state_in = S_WR_REQ;
            end else begin
               state_in = S_CHAR;
            end
         end

         S_WE_REQ: begin
            rd_en    = 1'b1;
            state_in = S_WE_CHK;
         end

         S_WE_CHK: begin
            // Trailing spaces first, then the word; stop at the space before it.
            if ((word_ff && is_space) || ptr_dec == '0) begin
               len_in   = we_end;
               res_in   = '{lew_pkg::ACT_ERASE, '0,
                            lew_pkg::CNT_W'(len_ff - we_end), 1'b1};
               ret_in   = S_IDLE;
               state_in = S_OUT;
            end else begin
               ptr_in   = ptr_dec;
               word_in  = word_ff || !is_space;
               state_in = S_WE_REQ;
            end
         end

         S_WR_REQ: begin
            rd_en    = 1'b1;
            state_in = S_WR_CHK;
         end

         S_WR_CHK: begin
            if (is_space && ptr_ff == LEN_MAX) begin
               // Full line ending in a space: a newline alone starts a fresh line.
               len_in   = '0;
               res_in   = '{lew_pkg::ACT_NEWLINE, '0, '0, 1'b0};
               ret_in   = S_CHAR;
               state_in = S_OUT;
            end else if (is_space || ptr_dec == '0) begin
               len_in    = keep;
               single_in = (wrap_start == '0);
               src_in    = wrap_start[AW-1:0];
               dst_in    = '0;
               res_in    = '{lew_pkg::ACT_ERASE, '0, lew_pkg::CNT_W'(keep), 1'b0};
               ret_in    = S_WR_NL;
               state_in  = S_OUT;
            end else begin
               ptr_in   = ptr_dec;
               state_in = S_WR_REQ;
            end
         end

         S_WR_NL: begin
            res_in   = '{lew_pkg::ACT_NEWLINE, '0, '0, 1'b0};
            ret_in   = S_MV_REQ;
            state_in = S_OUT;
         end

         S_MV_REQ: begin
            rd_en    = 1'b1;
            rd_addr  = src_ff;
            state_in = S_MV_CHK;
         end

         S_MV_CHK: begin
            // Move the partial word to the head of the line while retyping it.
            // On a single-word line a printable byte is dropped afterwards,
            // so the last retyped character closes the transfer sequence.
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = rd_data;
            res_in   = '{lew_pkg::ACT_ECHO, rd_data, '0,
                         mv_final && single_ff && printable};
            src_in   = src_ff + AW'(1);
            dst_in   = dst_ff + AW'(1);
            ret_in   = mv_final ? S_CHAR : S_MV_REQ;
            state_in = S_OUT;
         end

         S_CHAR: begin
            ret_in = S_IDLE;
            if (printable) begin
               if (len_ff != LEN_MAX) begin
                  wr_en    = 1'b1;
                  wr_addr  = len_ff[AW-1:0];
                  wr_data  = sym_ff;
                  len_in   = len_ff + LW'(1);
                  res_in   = '{lew_pkg::ACT_ECHO, sym_ff, '0, 1'b1};
                  state_in = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               res_in   = '{lew_pkg::ACT_BELL, '0, '0, 1'b1};
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (push_ready) begin
               state_in = ret_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      ptr_ff    <= ptr_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      word_ff   <= word_in;
      single_ff <= single_in;
      res_ff    <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign push      = (state_ff == S_OUT);
   assign push_data = res_ff;

endmodule

/* rtl/line_editor_word_wrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor with word wrap
// Terminal line editing of typed bytes with erase, kill, word erase and wrap.
// ----------------------------------------------------------------------------
// One typed byte is taken per req_ transfer (req_valid high, req_stall low).
// Each byte produces zero or more results on the rsp_ channel; rsp_last marks
// the final result of a byte. A byte that needs no result (erase on an empty
// line, for instance) produces no transfer at all.
// The block handles one byte at a time and holds req_stall high until every
// result of that byte has been handed to the output register. A single erase,
// kill or end report goes from the decode state straight to the output state,
// a plain echo or bell first through the character state, and the next byte
// can be taken once the sequencer is back in its idle state. A word erase
// walks the line store backwards one character per step (registered memory
// read, then compare). A wrap scans the last word the same way and then
// retypes it one character per step (read, move, hand over).
// When the receiver holds rsp_stall, the result waits in the output register
// and the sequencer stops at its next result until space frees.
// Reset empties the line, clears the output register and loads the default
// control characters; the line store itself is not cleared, as only entries
// below the line length are ever read. The csr_ port writes the control
// characters; the user must use it only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module line_editor_word_wrap #(
   parameter int LINE_LENGTH = lew_pkg::LINE_LENGTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lew_pkg::SYM_W-1:0]      req_symbol,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lew_pkg::ACT_W-1:0]      rsp_action,
   output logic [lew_pkg::SYM_W-1:0]      rsp_out_char,
   output logic [lew_pkg::CNT_W-1:0]      rsp_erase_count,
   output logic                           rsp_last,
   input  logic                           csr_write,
   input  logic [lew_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lew_pkg::SYM_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(LINE_LENGTH);
   localparam int LW = $clog2(LINE_LENGTH + 1);

   lew_pkg::cfg_type    cfg_ff, cfg_in;
   lew_pkg::result_type push_data;
   logic                push;
   logic                push_ready;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [lew_pkg::SYM_W-1:0] wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [lew_pkg::SYM_W-1:0] rd_data;

   // Control character registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            lew_pkg::CSR_ERASE:      cfg_in.erase_char      = csr_wdata;
            lew_pkg::CSR_KILL:       cfg_in.kill_char       = csr_wdata;
            lew_pkg::CSR_WORD_ERASE: cfg_in.word_erase_char = csr_wdata;
            lew_pkg::CSR_END:        cfg_in.end_char        = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.erase_char      <= lew_pkg::ERASE_CHAR_RST;
         cfg_ff.kill_char       <= lew_pkg::KILL_CHAR_RST;
         cfg_ff.word_erase_char <= lew_pkg::WORD_ERASE_CHAR_RST;
         cfg_ff.end_char        <= lew_pkg::END_CHAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lew_ctrl #(
      .LINE_LENGTH (LINE_LENGTH),
      .AW          (AW),
      .LW          (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   lew_store #(
      .DEPTH (LINE_LENGTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lew_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_data       (push_data),
      .push_ready      (push_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_out_char    (rsp_out_char),
      .rsp_erase_count (rsp_erase_count),
      .rsp_last        (rsp_last)
   );

endmodule

/* rtl/lew_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor port checker
// Port-level assertions on the line editor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lew_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lew_pkg::ACT_W-1:0]     rsp_action,
   input logic [lew_pkg::SYM_W-1:0]     rsp_out_char,
   input logic [lew_pkg::CNT_W-1:0]     rsp_erase_count,
   input logic                          rsp_last
);

   // A stalled result keeps its place and its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_action) && $stable(rsp_out_char) && $stable(rsp_erase_count) && $stable(rsp_last), "stalled result changed")

   // Each byte is worked on alone, so the input stalls right after a transfer.
   `ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall, "byte taken while busy")

   // Only echo results carry a character.
   `ASSERT_IMPL(a_char_zero, clock, reset, rsp_valid && rsp_action != lew_pkg::ACT_ECHO, rsp_out_char == '0, "character on a non-echo result")

   // An erase always removes at least one character.
   `ASSERT_IMPL(a_erase_nonzero, clock, reset, rsp_valid && rsp_action == lew_pkg::ACT_ERASE, rsp_erase_count != '0, "erase of zero characters")

endmodule

bind line_editor_word_wrap lew_checker u_lew_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_action      (rsp_action),
   .rsp_out_char    (rsp_out_char),
   .rsp_erase_count (rsp_erase_count),
   .rsp_last        (rsp_last)
);

/* verif/line_editor_word_wrap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor result checker
// Follows every typed byte and control write, predicts the terminal actions
// that each byte causes and compares every result transfer with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module line_editor_word_wrap_checker
   import lew_pkg::*;
#(
   parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [SYM_W-1:0]     req_symbol,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [ACT_W-1:0]     rsp_action,
   input  logic [SYM_W-1:0]     rsp_out_char,
   input  logic [CNT_W-1:0]     rsp_erase_count,
   input  logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SYM_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   outstanding,
   output int                   bytes_taken,
   output int                   results_checked,
   output int                   wraps_seen,
   output int                   ends_seen
);

   cfg_type          ctrl;
   logic [SYM_W-1:0] line_store [LINE_LENGTH];
   int               line_len;
   result_type       expected_actions [$];

   int mismatch_count = 0;
   int byte_count = 0;
   int result_count = 0;
   int wrap_count = 0;
   int end_count = 0;

   assign mismatches      = mismatch_count;
   assign bytes_taken     = byte_count;
   assign results_checked = result_count;
   assign wraps_seen      = wrap_count;
   assign ends_seen       = end_count;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   function automatic result_type make_action(input logic [ACT_W-1:0] act,
                                              input logic [SYM_W-1:0] ch, input int cnt);
      result_type r;
      r.action      = act;
      r.out_char    = ch;
      r.erase_count = CNT_W'(cnt);
      r.last        = 1'b0;
      return r;
   endfunction

   // Applies one typed byte to the shadow line and queues the actions it causes.
   task automatic edit_line(input logic [SYM_W-1:0] sym);
      result_type step_actions [$];
      result_type tail;
      int len;
      int cnt;
      int start;
      int keep;
      len = line_len;
      if (sym == ctrl.erase_char) begin
         if (len > 0) begin
            len--;
            step_actions.push_back(make_action(ACT_ERASE, '0, 1));
         end
      end else if (sym == ctrl.kill_char) begin
         if (len > 0) begin
            step_actions.push_back(make_action(ACT_ERASE, '0, len));
            len = 0;
         end
      end else if (sym == ctrl.word_erase_char) begin
         cnt = 0;
         while (len > 0 && line_store[len-1] == CHAR_SPACE) begin
            len--;
            cnt++;
         end
         while (len > 0 && line_store[len-1] != CHAR_SPACE) begin
            len--;
            cnt++;
         end
         if (cnt > 0) begin
            step_actions.push_back(make_action(ACT_ERASE, '0, cnt));
         end
      end else if (sym == ctrl.end_char && len == 0) begin
         step_actions.push_back(make_action(ACT_END, '0, 0));
         end_count++;
      end else begin
         if (len >= LINE_LENGTH) begin
            wrap_count++;
            if (line_store[LINE_LENGTH-1] != CHAR_SPACE) begin
               // Move the trailing partial word to the start and retype it.
               start = LINE_LENGTH;
               while (start > 0 && line_store[start-1] != CHAR_SPACE) begin
                  start--;
               end
               keep = LINE_LENGTH - start;
               for (int k = 0; k < keep; k++) begin
                  line_store[k] = line_store[start+k];
               end
               step_actions.push_back(make_action(ACT_ERASE, '0, keep));
               step_actions.push_back(make_action(ACT_NEWLINE, '0, 0));
               for (int k = 0; k < keep; k++) begin
                  step_actions.push_back(make_action(ACT_ECHO, line_store[k], 0));
               end
               len = keep;
            end else begin
               len = 0;
               step_actions.push_back(make_action(ACT_NEWLINE, '0, 0));
            end
         end
         if (sym >= CHAR_SPACE && sym <= CHAR_TILDE) begin
            if (len < LINE_LENGTH) begin
               line_store[len] = sym;
               len++;
               step_actions.push_back(make_action(ACT_ECHO, sym, 0));
            end
         end else begin
            step_actions.push_back(make_action(ACT_BELL, '0, 0));
         end
      end
      line_len = len;
      if (step_actions.size() > 0) begin
         tail = step_actions.pop_back();
         tail.last = 1'b1;
         step_actions.push_back(tail);
      end
      foreach (step_actions[i]) begin
         expected_actions.push_back(step_actions[i]);
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got.action      = rsp_action;
      got.out_char    = rsp_out_char;
      got.erase_count = rsp_erase_count;
      got.last        = rsp_last;
      result_count++;
      if (expected_actions.size() == 0) begin
         report_mismatch($sformatf(
            "result %0d with nothing expected: action %0d char %02h count %0d last %0b",
            result_count, got.action, got.out_char, got.erase_count, got.last));
      end else begin
         want = expected_actions.pop_front();
         if (got.action !== want.action || got.out_char !== want.out_char ||
             got.erase_count !== want.erase_count || got.last !== want.last) begin
            report_mismatch($sformatf(
               {"result %0d: got action %0d char %02h count %0d last %0b, ",
                "expected action %0d char %02h count %0d last %0b"},
               result_count, got.action, got.out_char, got.erase_count,
               got.last, want.action, want.out_char, want.erase_count,
               want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ctrl.erase_char      = ERASE_CHAR_RST;
         ctrl.kill_char       = KILL_CHAR_RST;
         ctrl.word_erase_char = WORD_ERASE_CHAR_RST;
         ctrl.end_char        = END_CHAR_RST;
         line_len = 0;
         expected_actions.delete();
         outstanding <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ERASE:      ctrl.erase_char      = csr_wdata;
               CSR_KILL:       ctrl.kill_char       = csr_wdata;
               CSR_WORD_ERASE: ctrl.word_erase_char = csr_wdata;
               CSR_END:        ctrl.end_char        = csr_wdata;
               default: ;
            endcase
         end
         // Results are compared before the byte of this edge is applied, so
         // the tail of the previous byte is matched first.
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            byte_count++;
            edit_line(req_symbol);
         end
         outstanding <= expected_actions.size();
      end
   end

endmodule

/* verif/line_editor_word_wrap_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line editor testbench
// Types directed and random byte sequences into the word-wrap line editor
// under several control character settings, with random sender gaps and
// receiver stalls; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module line_editor_word_wrap_test;
   import lew_pkg::*;

   localparam int LINE_LENGTH      = LINE_LENGTH_DEF;
   // A wrap of a single-word line is the slowest thing the block does, so
   // this many cycles is plenty for it to go quiet after a byte with no result.
   localparam int SETTLE_CYCLES    = 5 * LINE_LENGTH + 20;
   // Cycles with no transfer at all before the run is declared hung.
   localparam int IDLE_LIMIT       = 4000;
   localparam int OPENING_TARGET   = 110;
   localparam int RANDOM_PER_PHASE = 42;
   localparam int PHASE_COUNT      = 6;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SYM_W-1:0]     req_symbol = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ACT_W-1:0]     rsp_action;
   logic [SYM_W-1:0]     rsp_out_char;
   logic [CNT_W-1:0]     rsp_erase_count;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ERASE;
   logic [SYM_W-1:0]     csr_wdata = '0;

   int mismatches;
   int outstanding;
   int bytes_taken;
   int results_checked;
   int wraps_seen;
   int ends_seen;

   // The stimulus keeps its own copy of the control characters so that it can
   // type words that are not taken as editing commands.
   cfg_type ctrl = '{ERASE_CHAR_RST, KILL_CHAR_RST, WORD_ERASE_CHAR_RST, END_CHAR_RST};
   int      burst_left = 0;
   int      symbols_sent = 0;
   int      settings_used = 1;

   line_editor_word_wrap #(
      .LINE_LENGTH(LINE_LENGTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_out_char   (rsp_out_char),
      .rsp_erase_count(rsp_erase_count),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   line_editor_word_wrap_checker #(
      .LINE_LENGTH(LINE_LENGTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_out_char   (rsp_out_char),
      .rsp_erase_count(rsp_erase_count),
      .rsp_last       (rsp_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .bytes_taken    (bytes_taken),
      .results_checked(results_checked),
      .wraps_seen     (wraps_seen),
      .ends_seen      (ends_seen)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver keeps picking a new stall behaviour at random: sometimes it
   // never stalls, sometimes it stalls at random, on a short regular pattern,
   // or in long runs that hold a result in the output register for a while.
   // All of this happens at the falling edge, away from the sampling edge.
   int             stall_cycle = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_cycle % 150 == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
         end
         stall_cycle++;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 40);
            STALL_PERIODIC: rsp_stall <= (stall_cycle % 5 >= 3);
            default:        rsp_stall <= (stall_cycle % 16 < 7);
         endcase
      end
   end

   // Watchdog: any transfer on either channel restarts the count. The longest
   // quiet stretch of a correct run is a settling pause, far below the limit.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("No transfer for %0d cycles, %0d results still expected",
                     IDLE_LIMIT, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic bit is_control(input logic [SYM_W-1:0] v);
      return v == ctrl.erase_char || v == ctrl.kill_char ||
             v == ctrl.word_erase_char || v == ctrl.end_char;
   endfunction

   // A printable character other than the space that is not an editing command
   // under the current setting.
   function automatic logic [SYM_W-1:0] pick_letter();
      logic [SYM_W-1:0] v;
      do begin
         v = SYM_W'($urandom_range(int'(CHAR_SPACE) + 1, int'(CHAR_TILDE)));
      end while (is_control(v));
      return v;
   endfunction

   // A non-printable byte that is not an editing command, so it rings the bell.
   function automatic logic [SYM_W-1:0] pick_bell_byte();
      logic [SYM_W-1:0] v;
      do begin
         v = SYM_W'($urandom_range(0, 255));
      end while ((v >= CHAR_SPACE && v <= CHAR_TILDE) || is_control(v));
      return v;
   endfunction

   // Presents one byte and returns once it has been transferred. The task is
   // entered and left at a falling edge. The sender works in bursts: when one
   // ends, valid drops for a random gap (often none at all) before the next.
   // Within a burst valid stays high from byte to byte.
   task automatic send_symbol(input logic [SYM_W-1:0] sym);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      burst_left--;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      symbols_sent++;
   endtask

   // Holds the sender off until every expected result has arrived; with settle
   // set it then waits long enough for a byte without results to finish too,
   // which makes it safe to write the control registers.
   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
      if (settle) begin
         repeat (SETTLE_CYCLES) @(negedge clock);
      end
   endtask

   // Writes all four control characters on consecutive cycles. The write
   // enable stays high through the whole sequence and drops once at the end.
   task automatic apply_controls(input cfg_type c);
      logic [CSR_IDX_W-1:0] idx  [4];
      logic [SYM_W-1:0]     data [4];
      idx[0] = CSR_ERASE;      data[0] = c.erase_char;
      idx[1] = CSR_KILL;       data[1] = c.kill_char;
      idx[2] = CSR_WORD_ERASE; data[2] = c.word_erase_char;
      idx[3] = CSR_END;        data[3] = c.end_char;
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(negedge clock);
      end
      csr_write <= 1'b0;
      ctrl = c;
      settings_used++;
   endtask

   task automatic type_word(input int len);
      repeat (len) send_symbol(pick_letter());
   endtask

   // Clears the line and fills it so that its last character is a space; the
   // next byte then only gets a newline before it is handled.
   task automatic fill_ending_in_space();
      send_symbol(ctrl.kill_char);
      type_word(LINE_LENGTH - 1);
      send_symbol(CHAR_SPACE);
      send_symbol(pick_letter());
   endtask

   // Clears the line and fills it with one word. Each of the two further bytes
   // rewraps the same word; the printable one is then dropped, the other rings.
   task automatic fill_single_word();
      send_symbol(ctrl.kill_char);
      type_word(LINE_LENGTH);
      send_symbol(pick_letter());
      send_symbol(pick_bell_byte());
   endtask

   // Mostly plain typing (words of random length split by spaces, now and
   // then a long one that forces a wrap mid-word), mixed with editing
   // commands, random noise, bells, the two full-line sequences and the odd
   // pause in which the sender waits for every result to come back.
   task automatic random_traffic(input int target);
      int pick;
      while (symbols_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            type_word(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : 1) begin
               send_symbol(CHAR_SPACE);
            end
         end else if (pick < 72) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 3))
                  0:       send_symbol(ctrl.erase_char);
                  1:       send_symbol(ctrl.kill_char);
                  2:       send_symbol(ctrl.word_erase_char);
                  default: send_symbol(ctrl.end_char);
               endcase
            end
         end else if (pick < 90) begin
            send_symbol(SYM_W'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            send_symbol(pick_bell_byte());
         end else if (pick < 97) begin
            fill_ending_in_space();
         end else if (pick < 99) begin
            fill_single_word();
         end else begin
            wait_drained(1'b0);
         end
      end
   endtask

   initial begin
      cfg_type phase_ctrl [PHASE_COUNT];

      // Extremes of the register range, then settings where several commands
      // share one byte so that the priority order decides, a printable
      // word-erase and end character, and finally the reset values again.
      phase_ctrl[0] = '{8'h00, 8'hFF, 8'h08, 8'h1A};
      phase_ctrl[1] = '{8'h41, 8'h41, 8'h41, 8'h41};
      phase_ctrl[2] = '{8'hFF, 8'h7E, 8'h7E, 8'h7E};
      phase_ctrl[3] = '{8'h7F, 8'h15, 8'h2E, 8'h2E};
      phase_ctrl[4] = '{8'h08, 8'h18, 8'h17, 8'h65};
      phase_ctrl[5] = '{ERASE_CHAR_RST, KILL_CHAR_RST, WORD_ERASE_CHAR_RST, END_CHAR_RST};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening sequence under the reset setting. End of input on an empty
      // line, then each erase command with nothing to erase.
      send_symbol(END_CHAR_RST);
      send_symbol(ERASE_CHAR_RST);
      send_symbol(KILL_CHAR_RST);
      send_symbol(WORD_ERASE_CHAR_RST);
      // Bells at both ends of the byte range and at 8'h80, just above the erase character.
      send_symbol(8'h00);
      send_symbol(8'hFF);
      send_symbol(8'h80);
      // Line "A ~  ": a word erase takes both trailing spaces and the tilde.
      send_symbol(8'h41);
      send_symbol(CHAR_SPACE);
      send_symbol(CHAR_TILDE);
      send_symbol(CHAR_SPACE);
      send_symbol(CHAR_SPACE);
      send_symbol(WORD_ERASE_CHAR_RST);
      // End of input on a non-empty line is just a bell; then single erase,
      // kill, and a word erase of a one-letter line.
      send_symbol(END_CHAR_RST);
      send_symbol(ERASE_CHAR_RST);
      send_symbol(KILL_CHAR_RST);
      send_symbol(8'h7A);
      send_symbol(WORD_ERASE_CHAR_RST);

      // Both full-line cases are made certain once, then random typing.
      fill_ending_in_space();
      fill_single_word();
      random_traffic(OPENING_TARGET);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained(1'b1);
         apply_controls(phase_ctrl[p]);
         random_traffic(symbols_sent + RANDOM_PER_PHASE);
      end

      wait_drained(1'b1);

      $display("Typed %0d bytes under %0d control settings, with %0d full-line wraps",
               bytes_taken, settings_used, wraps_seen);
      $display("and %0d end-of-input reports; checked %0d result transfers, %0d mismatches.",
               ends_seen, results_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/lew_pkg.sv
rtl/lew_store.sv
rtl/lew_emit.sv
rtl/lew_ctrl.sv
rtl/line_editor_word_wrap.sv
rtl/lew_checker.sv
verif/line_editor_word_wrap_checker.sv
verif/line_editor_word_wrap_test.sv
